// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define SDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SDS_ASSERT_IMP(lbl, ante, cons, msg) \
  `SDS_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define SDS_ASSERT_NXT(lbl, ante, cons, msg) \
  `SDS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// types and constants of the scan disk scheduler
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int TRACK_W = 16;
  localparam int SEEK_W  = 17;
  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LAST_TRACK = 2'd0,
    REG_HEAD_POS   = 2'd1,
    REG_SWEEP_UP   = 2'd2
  } sds_reg_t;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_INSERT,
    CH_PUSH,
    CH_POP
  } sds_chain_op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEW,
    CELL_LEFT,
    CELL_RIGHT
  } sds_cell_op_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_SEEK,
    ST_PART,
    ST_ASC,
    ST_DESC
  } sds_state_t;

  typedef struct packed {
    sds_chain_op_t      op;
    logic [TRACK_W-1:0] data;
  } sds_chain_ctl_t;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic               batch_end;
  } sds_req_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic [SEEK_W-1:0]  seek_total;
    logic               overflow;
    logic               final_res;
  } sds_res_t;

endpackage

// ===== rtl/core/sds_cell.sv =====
// ----------------------------------------------------------------------------
// sds_cell
// one storage cell of a track chain: holds, loads, or takes a neighbor value
// ----------------------------------------------------------------------------
module sds_cell (
  input  logic                       clk,
  input  sds_pkg::sds_cell_op_t      op,
  input  logic [sds_pkg::TRACK_W-1:0] left,
  input  logic [sds_pkg::TRACK_W-1:0] right,
  input  logic [sds_pkg::TRACK_W-1:0] fresh,
  output logic [sds_pkg::TRACK_W-1:0] val,
  output logic                       gt
);
  import sds_pkg::*;

  logic [TRACK_W-1:0] val_next;

  assign gt = val > fresh;

  always_comb begin
    unique case (op)
      CELL_HOLD:  val_next = val;
      CELL_NEW:   val_next = fresh;
      CELL_LEFT:  val_next = left;
      CELL_RIGHT: val_next = right;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== rtl/core/sds_chain.sv =====
// ----------------------------------------------------------------------------
// sds_chain
// row of track cells with a fill count; sorted insert, push and pop at cell 0
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sds_chain #(
  parameter int DEPTH = 32,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sds_pkg::sds_chain_ctl_t     ctl,
  output logic [sds_pkg::TRACK_W-1:0] first,
  output logic [CW-1:0]               count
);
  import sds_pkg::*;

  logic [TRACK_W-1:0] vals [DEPTH];
  logic [DEPTH-1:0]   gt;
  logic [CW-1:0]      count_next;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TRACK_W-1:0] left;
    logic [TRACK_W-1:0] right;
    logic               take_left;
    logic               valid;
    sds_cell_op_t       op;

    if (i == 0) begin : g_first
      assign left      = ctl.data;
      assign take_left = 1'b0;
    end else begin : g_inner
      assign left      = vals[i-1];
      assign take_left = (count > CW'(i - 1)) && gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = ctl.data;
    end else begin : g_body
      assign right = vals[i+1];
    end

    assign valid = count > CW'(i);

    always_comb begin
      unique case (ctl.op)
        CH_HOLD: op = CELL_HOLD;
        CH_INSERT: begin
          if (take_left) begin
            op = CELL_LEFT;
          end else if ((count == CW'(i)) || (valid && gt[i])) begin
            op = CELL_NEW;
          end else begin
            op = CELL_HOLD;
          end
        end
        CH_PUSH: op = (i == 0) ? CELL_NEW : CELL_LEFT;
        CH_POP:  op = CELL_RIGHT;
      endcase
    end

    sds_cell u_cell (
      .clk   (clk),
      .op    (op),
      .left  (left),
      .right (right),
      .fresh (ctl.data),
      .val   (vals[i]),
      .gt    (gt[i])
    );
  end

  assign first = vals[0];

  always_comb begin
    unique case (ctl.op)
      CH_INSERT, CH_PUSH: count_next = count + CW'(1);
      CH_POP:             count_next = count - CW'(1);
      CH_HOLD:            count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  `SDS_ASSERT(a_count_range, count <= CW'(DEPTH), "chain count above depth")
  `SDS_ASSERT_IMP(a_pop_nonempty, ctl.op == CH_POP, count != '0, "pop from empty chain")
  `SDS_ASSERT_IMP(a_add_not_full, (ctl.op == CH_INSERT) || (ctl.op == CH_PUSH),
                  count != CW'(DEPTH), "add to full chain")

endmodule

// ===== rtl/core/scan_disk_scheduler_unit.sv =====
// an accepted request enters the sorting chain in its accept cycle, or is dropped when full;
// after the batch_end request the unit computes the seek total, moves each request
// below the head onto the stack chain, then emits the results, with a turn unless
// every request lies ahead of the head in the sweep direction, and goes back to filling;
// requests at one per cycle while filling; results at one per cycle unless res_stall
// holds them; reset clears the request count and drop flag and loads register defaults
// ----------------------------------------------------------------------------
// scan_disk_scheduler_unit
// scan order scheduler built from a sorting chain and a stack chain
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scan_disk_scheduler_unit #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  sds_pkg::sds_req_t             req,
  output logic                          res_valid,
  input  logic                          res_stall,
  output sds_pkg::sds_res_t             res,
  input  logic                          wr_en,
  input  logic [sds_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [sds_pkg::TRACK_W-1:0]   wr_data
);
  import sds_pkg::*;

  localparam int CW = $clog2(MAX_REQUESTS + 1);

  logic [TRACK_W-1:0] last_track;
  logic [TRACK_W-1:0] head_pos;
  logic               sweep_up;

  sds_state_t         state, state_next;
  logic               dropped, dropped_next;
  logic [CW-1:0]      remaining, remaining_next;
  logic [TRACK_W-1:0] max_val, max_next;
  logic [TRACK_W-1:0] head_c, head_c_next;
  logic [SEEK_W-1:0]  seek, seek_next;

  sds_chain_ctl_t     sort_ctl, stack_ctl;
  logic [TRACK_W-1:0] sort_top, stack_top;
  logic [CW-1:0]      sort_count, stack_count;

  logic               accept, full, emit, emit_ok;
  logic [TRACK_W-1:0] track_c, emit_track, head_lim;
  logic               below, above;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      last_track <= TRACK_W'(199);
      head_pos   <= '0;
      sweep_up   <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LAST_TRACK: last_track <= wr_data;
        REG_HEAD_POS:   head_pos   <= wr_data;
        REG_SWEEP_UP:   sweep_up   <= wr_data[0];
        default: ;
      endcase
    end
  end

  sds_chain #(.DEPTH(MAX_REQUESTS), .CW(CW)) u_sort (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sort_ctl),
    .first (sort_top),
    .count (sort_count)
  );

  sds_chain #(.DEPTH(MAX_REQUESTS), .CW(CW)) u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (stack_ctl),
    .first (stack_top),
    .count (stack_count)
  );

  assign req_stall = state != ST_FILL;
  assign accept    = req_valid && !req_stall;
  assign full      = sort_count == CW'(MAX_REQUESTS);
  assign track_c   = (req.track > last_track) ? last_track : req.track;
  assign head_lim  = (head_pos > last_track) ? last_track : head_pos;
  assign below     = (sort_count != '0) && (sort_top < head_lim);
  assign above     = max_val >= head_lim;
  assign emit_ok   = !res_valid || !res_stall;

  always_comb begin
    state_next     = state;
    dropped_next   = dropped;
    remaining_next = remaining;
    max_next       = max_val;
    head_c_next    = head_c;
    seek_next      = seek;
    sort_ctl.op    = CH_HOLD;
    sort_ctl.data  = track_c;
    stack_ctl.op   = CH_HOLD;
    stack_ctl.data = sort_top;
    emit           = 1'b0;
    emit_track     = sort_top;
    unique case (state)
      ST_FILL: begin
        if (accept) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            sort_ctl.op = CH_INSERT;
            if ((sort_count == '0) || (track_c > max_val)) begin
              max_next = track_c;
            end
          end
          if (req.batch_end) begin
            state_next = ST_SEEK;
          end
        end
      end
      ST_SEEK: begin
        head_c_next    = head_lim;
        remaining_next = sort_count;
        if (sweep_up) begin
          seek_next = SEEK_W'(last_track - head_lim)
                    + (below ? SEEK_W'(last_track - sort_top) : '0);
        end else begin
          seek_next = SEEK_W'(head_lim) + (above ? SEEK_W'(max_val) : '0);
        end
        state_next = ST_PART;
      end
      ST_PART: begin
        if ((sort_count != '0) && (sort_top < head_c)) begin
          sort_ctl.op  = CH_POP;
          stack_ctl.op = CH_PUSH;
        end else begin
          state_next = sweep_up ? ST_ASC : ST_DESC;
        end
      end
      ST_ASC: begin
        if (remaining == '0) begin
          state_next   = ST_FILL;
          dropped_next = 1'b0;
        end else if (sort_count == '0) begin
          state_next = ST_DESC;
        end else if (emit_ok) begin
          emit           = 1'b1;
          sort_ctl.op    = CH_POP;
          remaining_next = remaining - CW'(1);
        end
      end
      ST_DESC: begin
        emit_track = stack_top;
        if (remaining == '0) begin
          state_next   = ST_FILL;
          dropped_next = 1'b0;
        end else if (stack_count == '0) begin
          state_next = ST_ASC;
        end else if (emit_ok) begin
          emit           = 1'b1;
          stack_ctl.op   = CH_POP;
          remaining_next = remaining - CW'(1);
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      dropped   <= 1'b0;
      remaining <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      dropped   <= dropped_next;
      remaining <= remaining_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    max_val <= max_next;
    head_c  <= head_c_next;
    seek    <= seek_next;
    if (emit) begin
      res.served_track <= emit_track;
      res.seek_total   <= seek;
      res.overflow     <= dropped;
      res.final_res    <= remaining == CW'(1);
    end
  end

  `SDS_ASSERT_NXT(a_final_drains, emit && (remaining == CW'(1)), remaining == '0,
                  "final result left work behind")
  `SDS_ASSERT(a_empty_on_fill, ((state != ST_FILL) ##1 (state == ST_FILL)) |->
              ((sort_count == '0) && (stack_count == '0)), "chains not empty after batch")
  `SDS_ASSERT_IMP(a_emit_source, emit,
                  ((state == ST_ASC) && (sort_count != '0)) ||
                  ((state == ST_DESC) && (stack_count != '0)), "result from empty chain")

endmodule
